// File: design/icseg_pkg.sv
// Shared constants and types for the interval coverage segmenter.
`default_nettype none

package icseg_pkg;

  localparam int unsigned SAMPLES  = 64;
  localparam int unsigned SAMPLE_W = $clog2(SAMPLES);
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned COORD_W  = 31;
  localparam int unsigned MASK_W   = 64;
  localparam int unsigned CNT_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE
  } state_e;

endpackage

`default_nettype wire

// File: design/interval_coverage_segmenter.sv
// Top level: sweep-line coverage segmenter with the active ends held in a RAM.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o | interval_start, interval_end,
//           |           |                        | sample_index, flush
//   out     | output    | out_valid_o / out_stall_i | seg_start, seg_end,
//           |           |                        | sample_mask, seg_number, last_of_run
//
// Every minimum-end search walks the end RAM one entry a cycle.
// An item runs at most as many searches as there are active samples, and no search runs
// when none is active.
// Reset is asynchronous; the end RAM has no reset, entries are read only under the mask.
// A result waits in the output register while the block works on; a stalled output
// holds the block only when the next result is ready.
`default_nettype none

module interval_coverage_segmenter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [icseg_pkg::COORD_W-1:0] interval_start_i,
  input  wire logic [icseg_pkg::COORD_W-1:0] interval_end_i,
  input  wire logic [icseg_pkg::IDX_W-1:0]   sample_index_i,
  input  wire logic                          flush_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [icseg_pkg::COORD_W-1:0] seg_start_o,
  output logic      [icseg_pkg::COORD_W-1:0] seg_end_o,
  output logic      [icseg_pkg::MASK_W-1:0]  sample_mask_o,
  output logic      [icseg_pkg::CNT_W-1:0]   seg_number_o,
  output logic                               last_of_run_o
);

  localparam int unsigned SW = icseg_pkg::SAMPLE_W;
  localparam int unsigned CW = icseg_pkg::COORD_W;
  localparam logic [SW-1:0] LAST_PTR = SW'(icseg_pkg::SAMPLES - 1);

  icseg_pkg::state_e state_q, state_d;

  // end RAM
  logic [CW-1:0] end_mem [icseg_pkg::SAMPLES];
  logic [CW-1:0] rdata_q;
  logic          mem_we;

  // item
  logic [CW-1:0] start_q, end_q;
  logic [SW-1:0] idx_q;
  logic          flush_q;

  // sweep state
  logic [icseg_pkg::SAMPLES-1:0] mask_q;
  logic [CW-1:0]                 segstart_q;
  logic [icseg_pkg::CNT_W-1:0]   cnt_q;

  // search
  logic [SW-1:0] ptr_q, cmp_idx_q, best_idx_q;
  logic          cmp_vld_q, found_q;
  logic [CW-1:0] best_q;

  // output register
  logic          ovld_q;
  logic [CW-1:0] o_start_q, o_end_q;
  logic [icseg_pkg::SAMPLES-1:0] o_mask_q;
  logic [icseg_pkg::CNT_W-1:0]   o_cnt_q;
  logic          o_last_q;

  logic                          idx_ok, accept, slot_free;
  logic                          retire_go, emit_req, act;
  logic [icseg_pkg::SAMPLES-1:0] mask_after;
  logic                          last_emit;

  assign idx_ok    = flush_i ||
                     ({1'b0, sample_index_i} < (icseg_pkg::IDX_W + 1)'(icseg_pkg::SAMPLES));
  assign accept    = in_valid_i && !in_stall_o;
  assign slot_free = !ovld_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      icseg_pkg::ST_IDLE: begin
        if (in_valid_i && idx_ok) begin
          state_d = (mask_q == '0) ? icseg_pkg::ST_DECIDE : icseg_pkg::ST_SCAN;
        end
      end
      icseg_pkg::ST_SCAN: begin
        if (ptr_q == LAST_PTR) begin
          state_d = icseg_pkg::ST_TAIL;
        end
      end
      icseg_pkg::ST_TAIL: state_d = icseg_pkg::ST_DECIDE;
      icseg_pkg::ST_DECIDE: begin
        if (act) begin
          if (retire_go) begin
            state_d = (mask_after == '0) ? icseg_pkg::ST_DECIDE : icseg_pkg::ST_SCAN;
          end else begin
            state_d = icseg_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = icseg_pkg::ST_IDLE;
    endcase
  end

  // outputs and decisions
  always_comb begin
    in_stall_o = (state_q != icseg_pkg::ST_IDLE);
    retire_go  = found_q && (flush_q || (best_q < start_q));
    mask_after = mask_q & ~(icseg_pkg::SAMPLES'(1) << best_idx_q);
    emit_req   = retire_go || (!flush_q && (mask_q != '0));
    act        = (state_q == icseg_pkg::ST_DECIDE) && (!emit_req || slot_free);
    mem_we     = act && !retire_go && !flush_q;
    last_emit  = retire_go ? (mask_after == '0) : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= icseg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // end RAM, one write and one read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      end_mem[idx_q] <= end_q;
    end
    rdata_q <= end_mem[ptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q <= interval_start_i;
      end_q   <= interval_end_i;
      idx_q   <= sample_index_i[SW-1:0];
      flush_q <= flush_i;
    end
  end

  // search walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      found_q    <= 1'b0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else begin
      ptr_q     <= (state_q == icseg_pkg::ST_SCAN) ? ptr_q + SW'(1) : '0;
      cmp_vld_q <= (state_q == icseg_pkg::ST_SCAN);
      cmp_idx_q <= ptr_q;
      if (accept || (act && retire_go)) begin
        found_q <= 1'b0;
      end else if (cmp_vld_q && mask_q[cmp_idx_q] && (!found_q || (rdata_q < best_q))) begin
        found_q    <= 1'b1;
        best_q     <= rdata_q;
        best_idx_q <= cmp_idx_q;
      end
    end
  end

  // sweep state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= '0;
      segstart_q <= '0;
      cnt_q      <= '0;
    end else if (act) begin
      if (emit_req) begin
        cnt_q <= cnt_q + icseg_pkg::CNT_W'(1);
      end
      if (retire_go) begin
        mask_q     <= mask_after;
        segstart_q <= best_q;
      end else if (!flush_q) begin
        mask_q     <= mask_q | (icseg_pkg::SAMPLES'(1) << idx_q);
        segstart_q <= start_q;
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (act && emit_req) begin
      ovld_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act && emit_req) begin
      o_start_q <= segstart_q;
      o_end_q   <= retire_go ? best_q : start_q;
      o_mask_q  <= mask_q;
      o_cnt_q   <= cnt_q;
      o_last_q  <= last_emit;
    end
  end

  assign out_valid_o   = ovld_q;
  assign seg_start_o   = o_start_q;
  assign seg_end_o     = o_end_q;
  assign sample_mask_o = icseg_pkg::MASK_W'(o_mask_q);
  assign seg_number_o  = o_cnt_q;
  assign last_of_run_o = o_last_q;

endmodule

`default_nettype wire

// File: design/icseg_checker.sv
// Port-level checks for the interval coverage segmenter, bound to the top level.
`default_nettype none

module icseg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic [icseg_pkg::IDX_W-1:0]   sample_index_i,
  input wire logic                          flush_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [icseg_pkg::COORD_W-1:0] seg_end_o,
  input wire logic [icseg_pkg::CNT_W-1:0]   seg_number_o,
  input wire logic                          last_of_run_o
);

  logic                        have_q;
  logic [icseg_pkg::CNT_W-1:0] num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      num_q  <= '0;
    end else if (out_valid_o && !out_stall_i) begin
      have_q <= 1'b1;
      num_q  <= seg_number_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(seg_end_o) && $stable(seg_number_o))
    else $error("output word changed while stalled");

  a_busy_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (flush_i || ({1'b0, sample_index_i} < (icseg_pkg::IDX_W + 1)'(icseg_pkg::SAMPLES)))
    |=> in_stall_o)
    else $error("accepted item left no busy cycle");

  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("run not closed but input taken");

  a_seg_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && have_q |-> seg_number_o == num_q + icseg_pkg::CNT_W'(1))
    else $error("segment number skipped");

endmodule

bind interval_coverage_segmenter icseg_checker u_icseg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .sample_index_i (sample_index_i),
  .flush_i        (flush_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .seg_end_o      (seg_end_o),
  .seg_number_o   (seg_number_o),
  .last_of_run_o  (last_of_run_o)
);

`default_nettype wire

// File: sim/testbench.sv
// Testbench for the interval coverage segmenter: sweep-line prediction and result check.
`timescale 1ns / 100ps

module testbench;

  typedef logic [icseg_pkg::COORD_W-1:0] coord_t;
  typedef logic [icseg_pkg::IDX_W-1:0]   idx_t;
  typedef logic [icseg_pkg::MASK_W-1:0]  mask_t;
  typedef logic [icseg_pkg::CNT_W-1:0]   count_t;

  typedef struct packed {
    coord_t from_pos;
    coord_t to_pos;
    mask_t  mask;
    count_t number;
    logic   last;
  } segment_t;

  localparam int unsigned RANDOM_WORDS = 350;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned TAIL_CYCLES  = 2 + (icseg_pkg::SAMPLES + 1) * (icseg_pkg::SAMPLES + 2);
  localparam int unsigned PRINT_LIMIT  = 100;
  localparam coord_t      COORD_MAX    = '1;

  class segment_scoreboard;
    coord_t     ends [icseg_pkg::SAMPLES];
    mask_t      active;
    coord_t     seg_from;
    count_t     seg_count;
    segment_t   segments [$];
    int unsigned errors;

    function new();
      active    = '0;
      seg_from  = '0;
      seg_count = '0;
      errors    = 0;
      foreach (ends[i]) ends[i] = '0;
    endfunction

    task flag_mismatch(string msg);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int shortest_sample();
      int found;
      found = -1;
      for (int i = 0; i < icseg_pkg::SAMPLES; i++) begin
        if (active[i] && (found < 0 || ends[i] < ends[found])) found = i;
      end
      return found;
    endfunction

    function void add_segment(coord_t to_pos);
      segment_t seg;
      seg.from_pos = seg_from;
      seg.to_pos   = to_pos;
      seg.mask     = active;
      seg.number   = seg_count;
      seg.last     = 1'b0;
      segments.push_back(seg);
      seg_count++;
    endfunction

    function void retire_sample(int s);
      add_segment(ends[s]);
      active[s] = 1'b0;
      seg_from  = ends[s];
    endfunction

    // Predict the segments caused by one accepted input word.
    function void note_word(coord_t start, coord_t stop, idx_t idx, logic flush);
      int       n0;
      int       s;
      segment_t tail;
      n0 = segments.size();
      if (flush) begin
        while (active != '0) retire_sample(shortest_sample());
      end else begin
        s = shortest_sample();
        while (s >= 0 && ends[s] < start) begin
          retire_sample(s);
          s = shortest_sample();
        end
        if (active != '0) add_segment(start);
        ends[idx]   = stop;
        active[idx] = 1'b1;
        seg_from    = start;
      end
      if (segments.size() > n0) begin
        tail = segments.pop_back();
        tail.last = 1'b1;
        segments.push_back(tail);
      end
    endfunction

    task check_segment(segment_t got);
      segment_t want;
      if (segments.size() == 0) begin
        flag_mismatch($sformatf("unexpected segment #%0d [%0h,%0h]",
                                got.number, got.from_pos, got.to_pos));
      end else begin
        want = segments.pop_front();
        if (got.from_pos !== want.from_pos)
          flag_mismatch($sformatf("seg #%0d seg_start %0h, want %0h",
                                  want.number, got.from_pos, want.from_pos));
        if (got.to_pos !== want.to_pos)
          flag_mismatch($sformatf("seg #%0d seg_end %0h, want %0h",
                                  want.number, got.to_pos, want.to_pos));
        if (got.mask !== want.mask)
          flag_mismatch($sformatf("seg #%0d sample_mask %0h, want %0h",
                                  want.number, got.mask, want.mask));
        if (got.number !== want.number)
          flag_mismatch($sformatf("seg_number %0h, want %0h", got.number, want.number));
        if (got.last !== want.last)
          flag_mismatch($sformatf("seg #%0d last_of_run %0b, want %0b",
                                  want.number, got.last, want.last));
      end
    endtask

    task flag_leftovers();
      while (segments.size() != 0) begin
        flag_mismatch($sformatf("segment #%0d never arrived", segments[0].number));
        void'(segments.pop_front());
      end
    endtask
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   in_valid;
  logic   in_stall;
  coord_t interval_start;
  coord_t interval_end;
  idx_t   sample_index;
  logic   flush;
  logic   out_valid;
  logic   out_stall;
  coord_t seg_start;
  coord_t seg_end;
  mask_t  sample_mask;
  count_t seg_number;
  logic   last_of_run;

  bit          in_quiet;
  bit          out_quiet;
  int unsigned words_sent;
  int unsigned idle_cycles;

  segment_scoreboard sb = new();

  interval_coverage_segmenter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .interval_start_i (interval_start),
    .interval_end_i   (interval_end),
    .sample_index_i   (sample_index),
    .flush_i          (flush),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .seg_start_o      (seg_start),
    .seg_end_o        (seg_end),
    .sample_mask_o    (sample_mask),
    .seg_number_o     (seg_number),
    .last_of_run_o    (last_of_run)
  );

  always #5 clk_i = ~clk_i;

  // Result side: random stall per word, checked at the rising edge.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      hold = out_quiet ? 0 : $urandom_range(0, 19);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      sb.check_segment({seg_start, seg_end, sample_mask, seg_number, last_of_run});
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_word(coord_t start, coord_t stop, idx_t idx, logic fl);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    interval_start <= start;
    interval_end   <= stop;
    sample_index   <= idx;
    flush          <= fl;
    in_valid       <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    sb.note_word(start, stop, idx, fl);
    words_sent++;
  endtask

  task automatic send_interval(coord_t start, coord_t stop, idx_t idx);
    send_word(start, stop, idx, 1'b0);
  endtask

  // Interval fields of a flush are don't-care; fill them with noise.
  task automatic send_flush();
    send_word(coord_t'($urandom), coord_t'($urandom), idx_t'($urandom), 1'b1);
  endtask

  task automatic run_chromosome(bit wide);
    int unsigned count;
    int unsigned pool;
    int unsigned step_max;
    int unsigned len_max;
    coord_t      pos;
    coord_t      stop;
    idx_t        idx;
    in_quiet  = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    count    = wide ? icseg_pkg::SAMPLES : $urandom_range(1, 24);
    pool     = $urandom_range(1, icseg_pkg::SAMPLES);
    step_max = 1 << $urandom_range(0, 12);
    len_max  = 1 << $urandom_range(0, 16);
    pos = ($urandom_range(0, 3) == 0) ? '0 : coord_t'($urandom_range(0, 32'h7FF00000));
    for (int i = 0; i < count; i++) begin
      idx = wide ? idx_t'(i) : idx_t'($urandom_range(0, pool - 1));
      case ($urandom_range(0, 15))
        0:       stop = COORD_MAX;
        1:       stop = coord_t'($urandom);
        default: stop = pos + coord_t'($urandom_range(0, len_max));
      endcase
      send_interval(pos, stop, idx);
      pos += coord_t'($urandom_range(0, step_max));
    end
    // Now and then the chromosome runs on without its flush.
    if ($urandom_range(0, 7) != 0) send_flush();
  endtask

  task automatic run_noise();
    int unsigned count;
    count = $urandom_range(1, 3);
    repeat (count) begin
      send_word(coord_t'($urandom), coord_t'($urandom), idx_t'($urandom),
                logic'($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int unsigned base;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    interval_start = '0;
    interval_end   = '0;
    sample_index   = '0;
    flush          = 1'b0;
    in_quiet       = 1'b0;
    out_quiet      = 1'b0;
    words_sent     = 0;
    idle_cycles    = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty flush, ties on end, overwrite, inverted and out-of-order words
    send_flush();
    send_interval(31'd0, 31'd100, 6'd0);
    send_interval(31'd0, 31'd100, 6'd63);
    send_interval(31'd50, 31'd100, 6'd5);
    send_interval(31'd200, 31'd300, 6'd1);
    send_interval(31'd250, 31'd260, 6'd1);
    send_interval(31'd240, 31'd10, 6'd2);
    send_interval(31'd240, 31'd240, 6'd3);
    send_flush();
    send_interval(COORD_MAX, COORD_MAX, 6'd63);
    send_interval(COORD_MAX, 31'd0, 6'd0);
    send_interval(31'd0, COORD_MAX, 6'd62);
    send_flush();
    send_interval(31'h2AAAAAAA, 31'h55555555, 6'h2A);
    send_interval(31'h55555555, 31'h7FFFFFFE, 6'h15);
    send_interval(31'h55555556, 31'h55555555, 6'h15);
    send_flush();
    send_flush();

    base = words_sent;
    run_chromosome(1'b1);
    while (words_sent - base < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0:       run_noise();
        1:       run_chromosome($urandom_range(0, 7) == 0);
        default: run_chromosome(1'b0);
      endcase
    end
    send_flush();

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.segments.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
